// ===== hw/rtl/dwpst_pkg.sv =====
// Shared types and constants for the dual-wheel PID speed trim.
`timescale 1ns / 1ps

package dwpst_pkg;

  localparam int COUNT_BITS_DEF = 12;
  localparam int SUM_BITS_DEF   = 32;

  localparam int SPEED_W = 15;
  localparam int GAIN_W  = 16;
  localparam int BAND_W  = 8;
  localparam int DUTY_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_RIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND   = 3'd5;

  localparam logic [SPEED_W-1:0] SPEED_RST  = 15'd15000;
  localparam logic [GAIN_W-1:0]  GAIN_P_RST = 16'd1966;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST = 16'd9830;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST = 16'd328;
  localparam logic [BAND_W-1:0]  BAND_RST   = 8'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_I,
    ST_ADD_I,
    ST_CLAMP,
    ST_MUL_DUTY,
    ST_STORE,
    ST_OUT
  } state_t;

endpackage

// ===== hw/rtl/dwpst_in_if.sv =====
// Input channel carrying the target and encoder counts of one beat.
`timescale 1ns / 1ps

interface dwpst_in_if #(
  parameter int COUNT_BITS = dwpst_pkg::COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] target_count;
  logic [COUNT_BITS-1:0] left_count;
  logic [COUNT_BITS-1:0] right_count;

  modport source (output valid, output target_count, output left_count,
                  output right_count, input ready);
  modport sink (input valid, input target_count, input left_count,
                input right_count, output ready);
endinterface

// ===== hw/rtl/dwpst_out_if.sv =====
// Result channel carrying the two wheel duties of one beat.
`timescale 1ns / 1ps

interface dwpst_out_if;
  logic                           valid;
  logic                           ready;
  logic [dwpst_pkg::DUTY_W-1:0]   left_duty;
  logic [dwpst_pkg::DUTY_W-1:0]   right_duty;
  logic                           corrected;

  modport source (output valid, output left_duty, output right_duty,
                  output corrected, input ready);
  modport sink (input valid, input left_duty, input right_duty,
                input corrected, output ready);
endinterface

// ===== hw/rtl/dual_wheel_pid_speed_trim.sv =====
// Dual-wheel PID speed trim with deadband, built around one shared multiplier.
// A beat outside the deadband runs seven sequencer steps per wheel, wheels in turn;
// a beat inside the deadband goes straight from ST_IDLE to ST_OUT. The result beat is
// held in ST_OUT until out_ch.ready, and the next input beat is taken only back in ST_IDLE.
// Synchronous active-low reset restores the register defaults and clears the sequencer,
// integrator, history and held-duty state; the err, prod, acc and ob registers are not reset.
`timescale 1ns / 1ps

module dual_wheel_pid_speed_trim #(
  parameter int COUNT_BITS = dwpst_pkg::COUNT_BITS_DEF,
  parameter int SUM_BITS   = dwpst_pkg::SUM_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dwpst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dwpst_pkg::CFG_DATA_W-1:0]   cfg_data,
  dwpst_in_if.sink                           in_ch,
  dwpst_out_if.source                        out_ch
);

  localparam int EW  = COUNT_BITS + 1;
  localparam int DW  = COUNT_BITS + 2;
  localparam int SW0 = (SUM_BITS > EW) ? SUM_BITS : EW;
  localparam int SW  = SW0 + 1;
  localparam int MB0 = (SUM_BITS > DW) ? SUM_BITS : DW;
  localparam int MB  = (MB0 > 19) ? MB0 : 19;
  localparam int MA  = 18;
  localparam int PW  = MA + MB;
  localparam int AW  = 35;
  localparam int OBW = 18;

  localparam logic signed [PW-1:0] PW_ONE = PW'(65536);
  localparam logic signed [AW-1:0] A_ONE  = AW'(65536);
  localparam logic signed [AW-1:0] A_MONE = -AW'(65536);

  dwpst_pkg::state_t state_r, state_nxt;

  logic [dwpst_pkg::SPEED_W-1:0] speed_l_r, speed_r_r;
  logic [dwpst_pkg::GAIN_W-1:0]  gain_p_r, gain_d_r, gain_i_r;
  logic [dwpst_pkg::BAND_W-1:0]  band_r;

  logic signed [EW-1:0]       err_l_r, err_l_nxt, err_r_r, err_r_nxt;
  logic signed [EW-1:0]       prev_l_r, prev_l_nxt, prev_r_r, prev_r_nxt;
  logic signed [SUM_BITS-1:0] sum_l_r, sum_l_nxt, sum_r_r, sum_r_nxt;
  logic [dwpst_pkg::DUTY_W-1:0] held_l_r, held_l_nxt, held_r_r, held_r_nxt;
  logic                       corr_r, corr_nxt;
  logic                       wheel_r, wheel_nxt;
  logic signed [PW-1:0]       prod_r, prod_nxt;
  logic signed [AW-1:0]       acc_r, acc_nxt;
  logic [OBW-1:0]             ob_r, ob_nxt;

  logic signed [EW-1:0]       err_in_l, err_in_r, err_cur, prev_cur;
  logic signed [SUM_BITS-1:0] sum_cur, sum_upd;
  logic signed [DW-1:0]       diff;
  logic signed [SW-1:0]       sum_wide;
  logic                       quiet, in_acc;
  logic signed [MA-1:0]       mul_a;
  logic signed [MB-1:0]       mul_b;
  logic signed [31:0]         term32;
  logic signed [AW-1:0]       term_p, out_cl;

  assign in_acc = in_ch.valid && in_ch.ready;

  assign err_in_l = EW'({1'b0, in_ch.target_count}) - EW'({1'b0, in_ch.left_count});
  assign err_in_r = EW'({1'b0, in_ch.target_count}) - EW'({1'b0, in_ch.right_count});
  assign quiet = !err_in_l[EW-1] && (32'(err_in_l) <= 32'(band_r)) &&
                 !err_in_r[EW-1] && (32'(err_in_r) <= 32'(band_r));

  assign err_cur  = wheel_r ? err_r_r  : err_l_r;
  assign prev_cur = wheel_r ? prev_r_r : prev_l_r;
  assign sum_cur  = wheel_r ? sum_r_r  : sum_l_r;
  assign diff     = DW'(err_cur) - DW'(prev_cur);

  assign sum_wide = SW'(sum_cur) + SW'(err_cur);
  assign sum_upd  = (&sum_wide[SW-1:SUM_BITS-1] || ~|sum_wide[SW-1:SUM_BITS-1]) ?
                    sum_wide[SUM_BITS-1:0] :
                    {sum_wide[SW-1], {(SUM_BITS-1){~sum_wide[SW-1]}}};

  assign term32 = (&prod_r[PW-1:31] || ~|prod_r[PW-1:31]) ? prod_r[31:0] :
                  {prod_r[PW-1], {31{~prod_r[PW-1]}}};

  assign term_p = prod_r[PW-1] ? '0 : ((prod_r > PW_ONE) ? A_ONE : AW'(prod_r));

  assign out_cl = (acc_r > A_ONE) ? A_ONE : ((acc_r < A_MONE) ? '0 : acc_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      dwpst_pkg::ST_MUL_P: begin
        mul_a = MA'($signed({1'b0, gain_p_r}));
        mul_b = MB'(err_cur);
      end
      dwpst_pkg::ST_MUL_D: begin
        mul_a = MA'($signed({1'b0, gain_d_r}));
        mul_b = MB'(diff);
      end
      dwpst_pkg::ST_MUL_I: begin
        mul_a = MA'($signed({1'b0, gain_i_r}));
        mul_b = MB'(sum_cur);
      end
      dwpst_pkg::ST_MUL_DUTY: begin
        mul_a = MA'($signed({1'b0, (wheel_r ? speed_r_r : speed_l_r)}));
        mul_b = MB'($signed({1'b0, ob_r}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dwpst_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = quiet ? dwpst_pkg::ST_OUT : dwpst_pkg::ST_MUL_P;
      end
      dwpst_pkg::ST_MUL_P:    state_nxt = dwpst_pkg::ST_MUL_D;
      dwpst_pkg::ST_MUL_D:    state_nxt = dwpst_pkg::ST_MUL_I;
      dwpst_pkg::ST_MUL_I:    state_nxt = dwpst_pkg::ST_ADD_I;
      dwpst_pkg::ST_ADD_I:    state_nxt = dwpst_pkg::ST_CLAMP;
      dwpst_pkg::ST_CLAMP:    state_nxt = dwpst_pkg::ST_MUL_DUTY;
      dwpst_pkg::ST_MUL_DUTY: state_nxt = dwpst_pkg::ST_STORE;
      dwpst_pkg::ST_STORE:    state_nxt = wheel_r ? dwpst_pkg::ST_OUT : dwpst_pkg::ST_MUL_P;
      dwpst_pkg::ST_OUT: begin
        if (out_ch.ready) state_nxt = dwpst_pkg::ST_IDLE;
      end
      default:     state_nxt = dwpst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready       = (state_r == dwpst_pkg::ST_IDLE);
    out_ch.valid      = (state_r == dwpst_pkg::ST_OUT);
    out_ch.left_duty  = held_l_r;
    out_ch.right_duty = held_r_r;
    out_ch.corrected  = corr_r;

    err_l_nxt  = err_l_r;
    err_r_nxt  = err_r_r;
    prev_l_nxt = prev_l_r;
    prev_r_nxt = prev_r_r;
    sum_l_nxt  = sum_l_r;
    sum_r_nxt  = sum_r_r;
    held_l_nxt = held_l_r;
    held_r_nxt = held_r_r;
    corr_nxt   = corr_r;
    wheel_nxt  = wheel_r;
    prod_nxt   = PW'(mul_a) * PW'(mul_b);
    acc_nxt    = acc_r;
    ob_nxt     = ob_r;

    case (state_r)
      dwpst_pkg::ST_IDLE: begin
        if (in_acc) begin
          err_l_nxt = err_in_l;
          err_r_nxt = err_in_r;
          corr_nxt  = !quiet;
          wheel_nxt = 1'b0;
        end
      end
      dwpst_pkg::ST_MUL_D: acc_nxt = term_p;
      dwpst_pkg::ST_MUL_I: acc_nxt = acc_r + AW'(term32);
      dwpst_pkg::ST_ADD_I: begin
        acc_nxt = acc_r + AW'(term32);
        if (wheel_r) begin
          prev_r_nxt = err_cur;
          sum_r_nxt  = sum_upd;
        end else begin
          prev_l_nxt = err_cur;
          sum_l_nxt  = sum_upd;
        end
      end
      dwpst_pkg::ST_CLAMP: ob_nxt = OBW'(A_ONE + out_cl);
      dwpst_pkg::ST_STORE: begin
        if (wheel_r) held_r_nxt = prod_r[31:16];
        else held_l_nxt = prod_r[31:16];
        wheel_nxt = 1'b1;
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dwpst_pkg::ST_IDLE;
      speed_l_r <= dwpst_pkg::SPEED_RST;
      speed_r_r <= dwpst_pkg::SPEED_RST;
      gain_p_r  <= dwpst_pkg::GAIN_P_RST;
      gain_d_r  <= dwpst_pkg::GAIN_D_RST;
      gain_i_r  <= dwpst_pkg::GAIN_I_RST;
      band_r    <= dwpst_pkg::BAND_RST;
      prev_l_r  <= '0;
      prev_r_r  <= '0;
      sum_l_r   <= '0;
      sum_r_r   <= '0;
      held_l_r  <= '0;
      held_r_r  <= '0;
      corr_r    <= 1'b0;
      wheel_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      prev_l_r <= prev_l_nxt;
      prev_r_r <= prev_r_nxt;
      sum_l_r  <= sum_l_nxt;
      sum_r_r  <= sum_r_nxt;
      held_l_r <= held_l_nxt;
      held_r_r <= held_r_nxt;
      corr_r   <= corr_nxt;
      wheel_r  <= wheel_nxt;
      if (cfg_we) begin
        case (cfg_index)
          dwpst_pkg::CFG_SPEED_LEFT:  speed_l_r <= cfg_data[dwpst_pkg::SPEED_W-1:0];
          dwpst_pkg::CFG_SPEED_RIGHT: speed_r_r <= cfg_data[dwpst_pkg::SPEED_W-1:0];
          dwpst_pkg::CFG_GAIN_P:      gain_p_r  <= cfg_data[dwpst_pkg::GAIN_W-1:0];
          dwpst_pkg::CFG_GAIN_D:      gain_d_r  <= cfg_data[dwpst_pkg::GAIN_W-1:0];
          dwpst_pkg::CFG_GAIN_I:      gain_i_r  <= cfg_data[dwpst_pkg::GAIN_W-1:0];
          dwpst_pkg::CFG_DEAD_BAND:   band_r    <= cfg_data[dwpst_pkg::BAND_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    err_l_r <= err_l_nxt;
    err_r_r <= err_r_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    ob_r    <= ob_nxt;
  end

endmodule
